FILE: src/ata_pkg.sv
// Shared constants and tables for the accelerometer tilt block.
`timescale 1ns / 1ps
package ata_pkg;
	localparam int unsigned FIELD_W = 15;
	localparam int unsigned TABLE_LEN = 24;
	localparam int unsigned STEPS_DEFAULT = 16;
	localparam int unsigned ANGLE_LIMIT = 9000;
	// CORDIC datapath: Q.16 milli-g, values up to about 2^31, with growth
	localparam int unsigned CW = 36;
	localparam int unsigned AW = 32;

	function automatic logic [AW-1:0] atan_lut(input logic [4:0] i);
		logic [AW-1:0] r;
		unique case (i)
			5'd0:  r = 32'd294912000;
			5'd1:  r = 32'd174096719;
			5'd2:  r = 32'd91987925;
			5'd3:  r = 32'd46694507;
			5'd4:  r = 32'd23437865;
			5'd5:  r = 32'd11730358;
			5'd6:  r = 32'd5866610;
			5'd7:  r = 32'd2933484;
			5'd8:  r = 32'd1466764;
			5'd9:  r = 32'd733385;
			5'd10: r = 32'd366693;
			5'd11: r = 32'd183346;
			5'd12: r = 32'd91673;
			5'd13: r = 32'd45837;
			5'd14: r = 32'd22918;
			5'd15: r = 32'd11459;
			5'd16: r = 32'd5730;
			5'd17: r = 32'd2865;
			5'd18: r = 32'd1432;
			5'd19: r = 32'd716;
			5'd20: r = 32'd358;
			5'd21: r = 32'd179;
			5'd22: r = 32'd90;
			5'd23: r = 32'd45;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

FILE: src/ata_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module ata_isqrt #(
	parameter int unsigned NW = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NW-1:0]       radicand,
	output logic                done,
	output logic [NW/2-1:0]     root,
	output logic [NW/2:0]       rem
);
	localparam int unsigned RW = NW / 2;
	localparam int unsigned CNT_W = $clog2(RW + 1);

	logic [NW-1:0]  n_q;
	logic [RW+1:0]  r_q;
	logic [RW-1:0]  q_q;
	logic [CNT_W-1:0] cnt_q;
	logic           busy_q;
	logic [RW+1:0]  trial;
	logic [RW+1:0]  diff;

	assign trial = {r_q[RW-1:0], n_q[NW-1 -: 2]};
	assign diff  = trial - {q_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-3:0], 2'b00};
			if (!diff[RW+1]) begin
				r_q <= diff;
				q_q <= {q_q[RW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[RW-2:0], 1'b0};
			end
		end
	end

	assign root = q_q;
	assign rem  = r_q[RW:0];
endmodule

FILE: src/ata_lane.sv
// One tilt lane: Q.16 root of the cross axes, then a vectoring CORDIC.
`timescale 1ns / 1ps
module ata_lane #(
	parameter int unsigned CORDIC_STEPS = ata_pkg::STEPS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ata_pkg::FIELD_W-1:0] num,
	input  logic signed [ata_pkg::FIELD_W-1:0] p,
	input  logic signed [ata_pkg::FIELD_W-1:0] q,
	output logic                              done,
	output logic signed [ata_pkg::FIELD_W-1:0] angle
);
	localparam int unsigned CW = ata_pkg::CW;
	localparam int unsigned AW = ata_pkg::AW;
	localparam int unsigned NSTEP = (CORDIC_STEPS < ata_pkg::TABLE_LEN) ?
		CORDIC_STEPS : ata_pkg::TABLE_LEN;

	logic signed [29:0] pp, qq;
	logic [30:0] ss;
	logic        sq_done;
	logic [31:0] root;
	logic [32:0] rem_unused;
	logic signed [ata_pkg::FIELD_W-1:0] num_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [AW+1:0] acc_q;
	logic [4:0]  i_q;
	logic        run_q;
	logic signed [AW+1:0] rnd;
	logic signed [AW+1:0] r;
	logic        zero_q;

	assign pp = p * p;
	assign qq = q * q;
	assign ss = 31'(pp) + 31'(qq);

	ata_isqrt #(.NW(64)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(start),
		.radicand({1'b0, ss, 32'd0}),
		.done(sq_done), .root(root), .rem(rem_unused)
	);

	always_ff @(posedge clk) begin
		if (start) num_q <= num;
		if (sq_done) begin
			x_q   <= CW'(root);
			y_q   <= CW'({{(CW-ata_pkg::FIELD_W-16){num_q[ata_pkg::FIELD_W-1]}},
				num_q, 16'd0});
			acc_q <= '0;
		end else if (run_q) begin
			if (!y_q[CW-1]) begin
				x_q   <= x_q + (y_q >>> i_q);
				y_q   <= y_q - (x_q >>> i_q);
				acc_q <= acc_q + (AW+2)'(ata_pkg::atan_lut(i_q));
			end else begin
				x_q   <= x_q - (y_q >>> i_q);
				y_q   <= y_q + (x_q >>> i_q);
				acc_q <= acc_q - (AW+2)'(ata_pkg::atan_lut(i_q));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q   <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (sq_done) begin
				i_q <= '0;
				if (root == '0) done <= 1'b1;
				else run_q <= 1'b1;
			end else if (run_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 5'(NSTEP - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	assign rnd = (acc_q + (AW+2)'(32768)) >>> 16;
	always_comb begin
		if (x_q == '0 && !run_q) begin
			r = '0;
		end else if (rnd > $signed((AW+2)'(ata_pkg::ANGLE_LIMIT))) begin
			r = (AW+2)'(ata_pkg::ANGLE_LIMIT);
		end else if (rnd < -$signed((AW+2)'(ata_pkg::ANGLE_LIMIT))) begin
			r = -(AW+2)'(ata_pkg::ANGLE_LIMIT);
		end else begin
			r = rnd;
		end
	end

	// zero root bypasses the CORDIC: sign of the numerator picks the limit, zero gives zero
	always_ff @(posedge clk) if (sq_done) zero_q <= (root == '0);
	always_comb begin
		if (zero_q) begin
			if (num_q == '0) angle = '0;
			else if (num_q[ata_pkg::FIELD_W-1])
				angle = -ata_pkg::FIELD_W'(ata_pkg::ANGLE_LIMIT);
			else angle = ata_pkg::FIELD_W'(ata_pkg::ANGLE_LIMIT);
		end else begin
			angle = r[ata_pkg::FIELD_W-1:0];
		end
	end
endmodule

FILE: src/accel_tilt_angles_top.sv
// Top level: magnitude root and two tilt lanes with result merge.
`timescale 1ns / 1ps
// One sample in, one result out. The bit-serial 64-bit square roots run
// first and hand off to each lane's CORDIC, which does one step per cycle.
// The magnitude root and both tilt lanes run in parallel; a new sample is
// taken only when the block is idle and the result register is free, so a
// sample is not taken before the previous one is finished. The output
// register holds a result until transferred.
module accel_tilt_angles_top #(
	parameter int unsigned CORDIC_STEPS = ata_pkg::STEPS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ata_pkg::FIELD_W-1:0] accel_x,
	input  logic signed [ata_pkg::FIELD_W-1:0] accel_y,
	input  logic signed [ata_pkg::FIELD_W-1:0] accel_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ata_pkg::FIELD_W-1:0]        magnitude,
	output logic signed [ata_pkg::FIELD_W-1:0] roll_angle,
	output logic signed [ata_pkg::FIELD_W-1:0] pitch_angle
);
	localparam int unsigned W = ata_pkg::FIELD_W;

	logic busy_q, got_r_q, got_p_q, got_m_q;
	logic start;
	logic r_done, p_done, m_done;
	logic signed [W-1:0] r_ang, p_ang, r_hold_q, p_hold_q;
	logic [W-1:0] m_hold_q;
	logic signed [29:0] xx, yy, zz;
	logic [31:0] m_root;
	logic [32:0] m_rem;
	logic all_done;

	assign in_ready = !busy_q && !out_valid;
	assign start    = in_valid && in_ready;
	assign xx = accel_x * accel_x;
	assign yy = accel_y * accel_y;
	assign zz = accel_z * accel_z;

	ata_isqrt #(.NW(64)) u_mag (
		.clk(clk), .arst_n(arst_n), .start(start),
		.radicand({32'd0, 32'(xx) + 32'(yy) + 32'(zz)}),
		.done(m_done), .root(m_root), .rem(m_rem)
	);

	ata_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .arst_n(arst_n), .start(start),
		.num(accel_y), .p(accel_z), .q(accel_x),
		.done(r_done), .angle(r_ang)
	);

	ata_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .arst_n(arst_n), .start(start),
		.num(accel_x), .p(accel_y), .q(accel_z),
		.done(p_done), .angle(p_ang)
	);

	always_ff @(posedge clk) begin
		if (m_done) m_hold_q <= W'(m_root + 32'(m_rem > 33'(m_root)));
		if (r_done) r_hold_q <= -r_ang;
		if (p_done) p_hold_q <= p_ang;
	end

	assign all_done = (got_r_q || r_done) && (got_p_q || p_done) && (got_m_q || m_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; got_r_q <= 1'b0; got_p_q <= 1'b0; got_m_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				got_r_q <= 1'b0; got_p_q <= 1'b0; got_m_q <= 1'b0;
			end else if (busy_q) begin
				if (all_done) begin
					busy_q <= 1'b0;
					out_valid <= 1'b1;
				end else begin
					if (r_done) got_r_q <= 1'b1;
					if (p_done) got_p_q <= 1'b1;
					if (m_done) got_m_q <= 1'b1;
				end
			end
		end
	end

	assign magnitude   = m_hold_q;
	assign roll_angle  = r_hold_q;
	assign pitch_angle = p_hold_q;

`ifndef SYNTH
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_ready) else $error("sample taken while busy");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(magnitude) && $stable(pitch_angle))
		else $error("result changed while stalled");
	a_done_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(r_done || p_done) |-> busy_q) else $error("lane finished while idle");
	a_valid_after: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && all_done |=> out_valid) else $error("finished result not shown");
`endif
endmodule

FILE: bench/testbench.sv
// Testbench for accel_tilt_angles_top: predicts magnitude and tilt angles per sample.
`timescale 1ns / 1ps
module testbench;
	localparam int FIELD_W = ata_pkg::FIELD_W;
	localparam int STEPS = 16;
	localparam int N_RANDOM = 1750;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] z;
	} sample_t;

	typedef struct packed {
		logic [FIELD_W-1:0]        mag;
		logic signed [FIELD_W-1:0] roll;
		logic signed [FIELD_W-1:0] pitch;
	} tilt_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [FIELD_W-1:0] accel_x, accel_y, accel_z;
	logic [FIELD_W-1:0] magnitude;
	logic signed [FIELD_W-1:0] roll_angle, pitch_angle;

	sample_t pending_samples[$];
	tilt_t   expected_tilts[$];
	int      error_count = 0;
	bit      stimulus_done = 0;
	bit      quiet_phase = 0;
	int      send_gap = 0;
	int      recv_stall = 0;

	accel_tilt_angles_top #(.CORDIC_STEPS(STEPS)) uut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic longint atan_step(int i);
		longint t[24] = '{294912000, 174096719, 91987925, 46694507, 23437865,
			11730358, 5866610, 2933484, 1466764, 733385, 366693, 183346,
			91673, 45837, 22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};
		return t[i];
	endfunction

	function automatic longint root_floor(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// arithmetic shift on longint is floor division by 2^s
	function automatic longint tilt_angle(longint num, longint p, longint q);
		longint xv, yv, acc, dx, dy, r;
		xv = root_floor(longint'(p * p + q * q) << 32);
		yv = num * 65536;
		acc = 0;
		if (xv == 0) return (num > 0) ? 9000 : (num < 0) ? -9000 : 0;
		for (int i = 0; i < STEPS && i < ata_pkg::TABLE_LEN; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv += dx; yv -= dy; acc += atan_step(i);
			end else begin
				xv -= dx; yv += dy; acc -= atan_step(i);
			end
		end
		r = (acc + 32768) >>> 16;
		if (r > 9000) r = 9000;
		if (r < -9000) r = -9000;
		return r;
	endfunction

	function automatic tilt_t predict_tilt(sample_t s);
		longint x, y, z, sq, m;
		tilt_t t;
		x = s.x; y = s.y; z = s.z;
		sq = x * x + y * y + z * z;
		m = root_floor(sq);
		if (sq - m * m > m) m++;
		t.mag = m[FIELD_W-1:0];
		t.roll = FIELD_W'(-tilt_angle(y, z, x));
		t.pitch = FIELD_W'(tilt_angle(x, y, z));
		return t;
	endfunction

	function automatic logic signed [FIELD_W-1:0] rand_axis();
		case ($urandom_range(0, 9))
			0: return FIELD_W'($urandom);
			1: return FIELD_W'($signed($urandom_range(0, 40)) - 20);
			default: return FIELD_W'($signed($urandom_range(0, 32000)) - 16000);
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			accel_x <= '0; accel_y <= '0; accel_z <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) expected_tilts.push_back(predict_tilt({accel_x, accel_y, accel_z}));
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 0;
			end else if (pending_samples.size() > 0) begin
				sample_t s;
				s = pending_samples.pop_front();
				in_valid <= 1;
				accel_x <= s.x; accel_y <= s.y; accel_z <= s.z;
				if (!quiet_phase && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 18);
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				tilt_t e;
				if (expected_tilts.size() == 0) begin
					$display("%0t: unexpected result mag=%0d roll=%0d pitch=%0d", $time,
						magnitude, roll_angle, pitch_angle);
					error_count++;
				end else begin
					e = expected_tilts.pop_front();
					if (magnitude !== e.mag) begin
						$display("%0t: magnitude expected %0d actual %0d", $time, e.mag, magnitude);
						error_count++;
					end
					if (roll_angle !== e.roll) begin
						$display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_angle);
						error_count++;
					end
					if (pitch_angle !== e.pitch) begin
						$display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch_angle);
						error_count++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				out_ready <= 0;
			end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
				recv_stall <= $urandom_range(1, 18);
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	initial begin
		logic signed [FIELD_W-1:0] lim[6] = '{16000, -16000, 16383, -16384, 0, 1};
		sample_t s;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		// directed: zeros, single axes at extremes, equal axes, full-range codes
		pending_samples.push_back('{0, 0, 0});
		foreach (lim[i]) begin
			pending_samples.push_back('{lim[i], 0, 0});
			pending_samples.push_back('{0, lim[i], 0});
			pending_samples.push_back('{0, 0, lim[i]});
		end
		pending_samples.push_back('{16000, 16000, 16000});
		pending_samples.push_back('{-16384, -16384, -16384});
		pending_samples.push_back('{16383, -16384, 16383});
		pending_samples.push_back('{-1, -1, -1});
		for (int i = 0; i < N_RANDOM; i++) begin
			s.x = rand_axis(); s.y = rand_axis(); s.z = rand_axis();
			pending_samples.push_back(s);
		end
		// last stretch runs with no idling on either side
		wait (pending_samples.size() <= 200);
		quiet_phase = 1;
		wait (pending_samples.size() == 0 && !in_valid);
		wait (expected_tilts.size() == 0);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#20ms;
		$display("testbench NOT OK");
		$finish;
	end
endmodule
